>>> rtl/core/uws_pkg.sv
// Package for the unknown-word signature block: character codes, class codes,
// signature and word-state structures, and small character helpers.
// Has no dependencies; every other file uses it by scoped names.
package uws_pkg;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_CASE_OFFSET = 8'h20;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_G = 8'h67;
    localparam logic [7:0] CH_I = 8'h69;
    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_O = 8'h6F;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_Y = 8'h79;

    localparam logic [2:0] LEN_MAX = 3'd7;
    localparam logic [1:0] CAPS_MAX = 2'd3;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_INITC,
        CAP_INITC_KNOWNLC,
        CAP_CAPS,
        CAP_LC
    } cap_class_t;

    typedef enum logic [3:0] {
        SUF_NONE,
        SUF_S,
        SUF_ED,
        SUF_ING,
        SUF_ION,
        SUF_ER,
        SUF_EST,
        SUF_LY,
        SUF_ITY,
        SUF_Y,
        SUF_AL
    } suffix_class_t;

    // Word facts that gate the suffix rules.
    typedef struct packed {
        logic len_ge3;
        logic len_ge5;
        logic dash;
        logic digit;
        logic any_cap;
    } word_facts_t;

    typedef struct packed {
        cap_class_t    cap;
        logic          number;
        logic          hyphen;
        suffix_class_t suffix;
    } signature_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return is_upper(c) ? c + CH_CASE_OFFSET : c;
    endfunction

endpackage

>>> rtl/core/uws_suffix.sv
// Suffix classifier for the unknown-word signature block.
// Looks at the last three lower-cased characters and the word facts; uses uws_pkg.
module uws_suffix
(
    input  logic [2:0][7:0]      tail,
    input  uws_pkg::word_facts_t facts,
    output uws_pkg::suffix_class_t suffix
);

    logic ends_ed, ends_ing, ends_ion, ends_er, ends_est;
    logic ends_ly, ends_ity, ends_y, ends_al;
    logic long_ok;

    assign ends_ed  = (tail[1] == uws_pkg::CH_E) && (tail[0] == uws_pkg::CH_D);
    assign ends_ing = (tail[2] == uws_pkg::CH_I) && (tail[1] == uws_pkg::CH_N)
                   && (tail[0] == uws_pkg::CH_G);
    assign ends_ion = (tail[2] == uws_pkg::CH_I) && (tail[1] == uws_pkg::CH_O)
                   && (tail[0] == uws_pkg::CH_N);
    assign ends_er  = (tail[1] == uws_pkg::CH_E) && (tail[0] == uws_pkg::CH_R);
    assign ends_est = (tail[2] == uws_pkg::CH_E) && (tail[1] == uws_pkg::CH_S)
                   && (tail[0] == uws_pkg::CH_T);
    assign ends_ly  = (tail[1] == uws_pkg::CH_L) && (tail[0] == uws_pkg::CH_Y);
    assign ends_ity = (tail[2] == uws_pkg::CH_I) && (tail[1] == uws_pkg::CH_T)
                   && (tail[0] == uws_pkg::CH_Y);
    assign ends_y   = (tail[0] == uws_pkg::CH_Y);
    assign ends_al  = (tail[1] == uws_pkg::CH_A) && (tail[0] == uws_pkg::CH_L);

    assign long_ok = facts.len_ge5 && !facts.dash && !(facts.digit && facts.any_cap);

    always_comb
    begin
        suffix = uws_pkg::SUF_NONE;
        // A word ending in 's' never tries the longer suffixes.
        if (facts.len_ge3 && (tail[0] == uws_pkg::CH_S))
        begin
            if ((tail[1] != uws_pkg::CH_S) && (tail[1] != uws_pkg::CH_I)
                && (tail[1] != uws_pkg::CH_U))
            begin
                suffix = uws_pkg::SUF_S;
            end
        end
        else if (long_ok)
        begin
            if (ends_ed)       suffix = uws_pkg::SUF_ED;
            else if (ends_ing) suffix = uws_pkg::SUF_ING;
            else if (ends_ion) suffix = uws_pkg::SUF_ION;
            else if (ends_er)  suffix = uws_pkg::SUF_ER;
            else if (ends_est) suffix = uws_pkg::SUF_EST;
            else if (ends_ly)  suffix = uws_pkg::SUF_LY;
            else if (ends_ity) suffix = uws_pkg::SUF_ITY;
            else if (ends_y)   suffix = uws_pkg::SUF_Y;
            else if (ends_al)  suffix = uws_pkg::SUF_AL;
        end
    end

endmodule

>>> rtl/core/uws_accum.sv
// Per-word accumulator: running counts, flags and the lower-cased tail.
// Produces the signature of the word as it stands after the current character.
// Uses uws_pkg and instantiates uws_suffix.
module uws_accum
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [7:0]            char_code,
    input  logic                  is_last,
    input  logic                  sentence_start,
    input  logic                  lowercase_known,
    output uws_pkg::signature_t   signature
);

    logic [2:0]      length_reg, length_next;
    logic [1:0]      capital_reg, capital_next;
    logic            first_cap_reg, first_cap_next;
    logic            lower_reg, lower_next;
    logic            digit_reg, digit_next;
    logic            dash_reg, dash_next;
    logic [2:0][7:0] tail_reg, tail_next;

    logic                   upper_char;
    uws_pkg::word_facts_t   facts;
    uws_pkg::suffix_class_t suffix;
    uws_pkg::cap_class_t    cap;

    assign upper_char = uws_pkg::is_upper(char_code);

    always_comb
    begin
        first_cap_next = first_cap_reg || (upper_char && (length_reg == 3'd0));
        capital_next   = (upper_char && (capital_reg != uws_pkg::CAPS_MAX))
                       ? capital_reg + 2'd1 : capital_reg;
        lower_next     = lower_reg || uws_pkg::is_lower(char_code);
        digit_next     = digit_reg || ((char_code >= uws_pkg::CH_DIGIT_0)
                                    && (char_code <= uws_pkg::CH_DIGIT_9));
        dash_next      = dash_reg || (char_code == uws_pkg::CH_DASH);
        length_next    = (length_reg != uws_pkg::LEN_MAX) ? length_reg + 3'd1 : length_reg;
        tail_next[0]   = uws_pkg::fold(char_code);
        tail_next[1]   = tail_reg[0];
        tail_next[2]   = tail_reg[1];
    end

    always_comb
    begin
        if (first_cap_next)
        begin
            if (sentence_start && (capital_next == 2'd1))
                cap = lowercase_known ? uws_pkg::CAP_INITC_KNOWNLC : uws_pkg::CAP_INITC;
            else
                cap = uws_pkg::CAP_CAPS;
        end
        else
        begin
            cap = lower_next ? uws_pkg::CAP_LC : uws_pkg::CAP_NONE;
        end
    end

    assign facts.len_ge3 = (length_next >= 3'd3);
    assign facts.len_ge5 = (length_next >= 3'd5);
    assign facts.dash    = dash_next;
    assign facts.digit   = digit_next;
    assign facts.any_cap = (capital_next != 2'd0);

    uws_suffix u_suffix
    (
        .tail   (tail_next),
        .facts  (facts),
        .suffix (suffix)
    );

    assign signature.cap    = cap;
    assign signature.number = digit_next;
    assign signature.hyphen = dash_next;
    assign signature.suffix = suffix;

    // The last character of a word clears everything for the next word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            capital_reg   <= '0;
            first_cap_reg <= 1'b0;
            lower_reg     <= 1'b0;
            digit_reg     <= 1'b0;
            dash_reg      <= 1'b0;
            tail_reg      <= '0;
        end
        else if (advance)
        begin
            if (is_last)
            begin
                length_reg    <= '0;
                capital_reg   <= '0;
                first_cap_reg <= 1'b0;
                lower_reg     <= 1'b0;
                digit_reg     <= 1'b0;
                dash_reg      <= 1'b0;
                tail_reg      <= '0;
            end
            else
            begin
                length_reg    <= length_next;
                capital_reg   <= capital_next;
                first_cap_reg <= first_cap_next;
                lower_reg     <= lower_next;
                digit_reg     <= digit_next;
                dash_reg      <= dash_next;
                tail_reg      <= tail_next;
            end
        end
    end

endmodule

>>> rtl/core/unknown_word_signature.sv
// Unknown-word signature: takes one character per transaction, and on the
// character marked last delivers one signature transaction (capitalization
// class, digit flag, dash flag, suffix class). It accepts one character every
// cycle; a character goes through an input register and the accumulator, and
// a word's signature is held in the result register for the output. Only
// characters that end a word need room in the result register, so a stalled
// output holds back the input only when a word's last character is waiting.
// Uses uws_pkg; instantiates uws_accum.
module unknown_word_signature
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       is_last,
    input  logic       sentence_start,
    input  logic       lowercase_known,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] cap_class,
    output logic       has_number,
    output logic       has_hyphen,
    output logic [3:0] suffix_class
);

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       start_reg;
    logic       known_reg;

    logic                 out_valid_reg;
    uws_pkg::signature_t  sig_reg;
    uws_pkg::signature_t  signature;

    logic out_room;
    logic advance;
    logic emit;
    logic in_take;

    assign out_room = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!last_reg || out_room);
    assign emit     = advance && last_reg;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg  <= char_code;
            last_reg  <= is_last;
            start_reg <= sentence_start;
            known_reg <= lowercase_known;
        end
    end

    uws_accum u_accum
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .char_code       (char_reg),
        .is_last         (last_reg),
        .sentence_start  (start_reg),
        .lowercase_known (known_reg),
        .signature       (signature)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            sig_reg <= signature;
    end

    assign out_valid    = out_valid_reg;
    assign cap_class    = sig_reg.cap;
    assign has_number   = sig_reg.number;
    assign has_hyphen   = sig_reg.hyphen;
    assign suffix_class = sig_reg.suffix;

    // A new signature appears only after a word's last character was processed.
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(emit))
        else $error("signature raised without a last character");

    // A waiting last character never overwrites an undelivered signature.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !emit)
        else $error("signature overwritten while stalled");

    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cap_class <= 3'(uws_pkg::CAP_LC)))
        else $error("capitalization class out of range");

    a_suffix_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (suffix_class <= 4'(uws_pkg::SUF_AL)))
        else $error("suffix class out of range");

endmodule
